// ===== hdl/safp_pkg.sv =====
// Shared types and constants for the servo angle frame parser.
// No dependencies; imported by every module of the block.
package safp_pkg;

  // Number of servos held in the angle table.
  localparam int unsigned SERVO_COUNT = 16;
  localparam int unsigned SERVO_IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  // Reply frame layout: #IIIPAAAA!
  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN + 1);

  // Characters of the reply format.
  localparam logic [7:0] CH_START = 8'h23;  // '#'
  localparam logic [7:0] CH_END   = 8'h21;  // '!'
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  // Register reset values.
  localparam logic [15:0] LOW_LIMIT_RESET  = 16'd500;
  localparam logic [15:0] HIGH_LIMIT_RESET = 16'd2500;

  // Depth of the queue between the parser and the table.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Kind of an incoming item.
  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_LOW_LIMIT  = 1'b0,
    REG_HIGH_LIMIT = 1'b1
  } reg_idx_e;

  // Operation handed from the parser to the table.
  typedef struct packed {
    cmd_e        kind;   // CMD_BYTE: store decoded angle, CMD_QUERY: read back
    logic [7:0]  id;
    logic [15:0] angle;
  } op_t;

endpackage

// ===== hdl/safp_front.sv =====
// Front end of the servo angle frame parser: accepts items, tracks the
// reply frame and turns complete replies and queries into table operations.
// Depends on safp_pkg.
module safp_front
  import safp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cmd_e       in_kind_i,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] in_query_id_i,
  output logic       push_o,
  output op_t        push_op_o,
  input  logic       queue_full_i
);

  logic [POS_W-1:0] pos_q, pos_d, pos_next;
  logic [7:0]       id_q, id_d;
  logic [15:0]      angle_q, angle_d;
  logic             p_ok_q, p_ok_d;
  logic             accept;
  logic             take_byte;
  logic             frame_end;
  logic [7:0]       digit8;
  logic [15:0]      digit16;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take_byte  = accept && (in_kind_i == CMD_BYTE);

  // Digit values wrap at the width of the number they feed.
  assign digit8  = in_byte_i - CH_ZERO;
  assign digit16 = {8'd0, in_byte_i} - {8'd0, CH_ZERO};

  // Position after storing the byte; a full frame stays full.
  assign pos_next = (pos_q != '0 && pos_q < POS_W'(FRAME_LEN)) ? pos_q + POS_W'(1) : pos_q;

  // A terminator on a full frame ends it, decoded or not.
  assign frame_end = take_byte && (in_byte_i != CH_START) && (in_byte_i == CH_END)
                     && (pos_next == POS_W'(FRAME_LEN));

  // Frame tracking: ID and angle are accumulated digit by digit.
  always_comb begin
    pos_d   = pos_q;
    id_d    = id_q;
    angle_d = angle_q;
    p_ok_d  = p_ok_q;
    if (take_byte) begin
      if (in_byte_i == CH_START) begin
        pos_d   = POS_W'(1);
        id_d    = '0;
        angle_d = '0;
        p_ok_d  = 1'b0;
      end else begin
        if (pos_q >= POS_W'(1) && pos_q <= POS_W'(3)) begin
          id_d = 8'(id_q * 8'd10) + digit8;
        end
        if (pos_q == POS_W'(4)) begin
          p_ok_d = (in_byte_i == CH_P);
        end
        if (pos_q >= POS_W'(5) && pos_q <= POS_W'(8)) begin
          angle_d = 16'(angle_q * 16'd10) + digit16;
        end
        pos_d = frame_end ? '0 : pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Payload of the frame needs no reset: a start character sets it.
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    angle_q <= angle_d;
    p_ok_q  <= p_ok_d;
  end

  // Queries always go to the table; replies only when well formed and in range.
  always_comb begin
    push_o          = 1'b0;
    push_op_o.kind  = in_kind_i;
    push_op_o.id    = id_q;
    push_op_o.angle = angle_q;
    if (accept && in_kind_i == CMD_QUERY) begin
      push_o       = 1'b1;
      push_op_o.id = in_query_id_i;
    end else if (frame_end && p_ok_q && (32'(id_q) < SERVO_COUNT)) begin
      push_o = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  // The frame position never runs past a full frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= POS_W'(FRAME_LEN))
    else $error("frame position out of range");
  // A decoded reply always leaves the parser waiting for a new start character.
  assert property (@(posedge clk_i) disable iff (!rst_ni) frame_end |=> pos_q == '0)
    else $error("frame not closed after terminator");
`endif

endmodule

// ===== hdl/safp_queue.sv =====
// Short in-order queue of table operations between parser and table.
// Depends on safp_pkg.
module safp_queue
  import safp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  head_o
);

  op_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

`ifndef ASSERT_OFF
  // The parser never offers an operation while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  // The table never takes from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/safp_back.sv =====
// Back end of the servo angle frame parser: angle table, fresh flags,
// limit registers and the registered result stage.
// Depends on safp_pkg.
module safp_back
  import safp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  op_t         head_i,
  output logic        pop_o,
  input  logic        cfg_valid_i,
  input  reg_idx_e    cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_fresh_o,
  output logic        out_angle_valid_o,
  output logic [15:0] out_angle_o
);

  logic [15:0]          table_q [SERVO_COUNT];
  logic [SERVO_COUNT-1:0] fresh_q;
  logic [15:0]          low_q, high_q;
  logic                 out_valid_q;
  logic                 out_fresh_q, out_ok_q;
  logic [15:0]          out_angle_q;
  logic                 is_query;
  logic                 slot_free;
  logic [SERVO_IDX_W-1:0] idx;
  logic                 id_hit;
  logic                 rd_fresh;
  logic [15:0]          rd_angle;
  logic                 in_limits;

  assign is_query  = (head_i.kind == CMD_QUERY);
  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = !empty_i && (!is_query || slot_free);

  // Table lookup for the operation at the head of the queue.
  assign idx       = head_i.id[SERVO_IDX_W-1:0];
  assign id_hit    = (32'(head_i.id) < SERVO_COUNT);
  assign rd_fresh  = id_hit && fresh_q[idx];
  assign rd_angle  = table_q[idx];
  assign in_limits = (rd_angle > low_q) && (rd_angle < high_q);

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_LIMIT_RESET;
      high_q <= HIGH_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW_LIMIT:  low_q  <= cfg_data_i;
        REG_HIGH_LIMIT: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Angle table and fresh flags: replies store and mark, queries clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        table_q[i] <= '0;
      end
      fresh_q <= '0;
    end else if (pop_o) begin
      if (!is_query) begin
        table_q[idx] <= head_i.angle;
        fresh_q[idx] <= 1'b1;
      end else if (id_hit) begin
        fresh_q[idx] <= 1'b0;
      end
    end
  end

  // Result register: loaded by a query, emptied when the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && is_query) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_query) begin
      out_fresh_q <= rd_fresh;
      out_ok_q    <= rd_fresh && in_limits;
      out_angle_q <= (rd_fresh && in_limits) ? rd_angle : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_fresh_o       = out_fresh_q;
  assign out_angle_valid_o = out_ok_q;
  assign out_angle_o       = out_angle_q;

`ifndef ASSERT_OFF
  // A reported angle always comes from a fresh reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && out_ok_q |-> out_fresh_q)
    else $error("angle reported without fresh reading");
  // An angle that is not reported reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && !out_ok_q |-> out_angle_q == '0)
    else $error("unreported angle not zero");
`endif

endmodule

// ===== hdl/servo_angle_frame_parser.sv =====
// Top level of the servo angle frame parser: parser front end, operation
// queue and angle table back end. Depends on safp_pkg, safp_front,
// safp_queue and safp_back.
//
//  Channel   Dir  Handshake                       Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: command; tdata: rx_byte, query_id
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser: fresh, angle_valid; tdata: angle
//  cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i (limit registers)
//
// One item is accepted per cycle while the operation queue has room. A query
// enters the queue at the edge that accepts it; its result is loaded into the
// result register through the table read when it is popped. Received bytes give no result.
// After reset the limits are 500 and 2500, the table is zero and no reading
// is fresh. A stalled result stage holds queries in the two-entry queue;
// the input stalls only once that queue is full.
module servo_angle_frame_parser
  import safp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // [0] command
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] query_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // [0] fresh, [1] angle_valid
  output logic [15:0] m_axis_tdata,   // [15:0] angle
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic push, full, pop, empty;
  op_t  push_op, head;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  safp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (cmd_e'(s_axis_tuser)),
    .in_byte_i     (s_axis_tdata[7:0]),
    .in_query_id_i (s_axis_tdata[15:8]),
    .push_o        (push),
    .push_op_o     (push_op),
    .queue_full_i  (full)
  );

  safp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head)
  );

  safp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (reg_idx_e'(cfg_index_i)),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_fresh_o       (m_axis_tuser[0]),
    .out_angle_valid_o (m_axis_tuser[1]),
    .out_angle_o       (m_axis_tdata)
  );

endmodule

// ===== bench/servo_angle_frame_parser_test.sv =====
// Self-checking testbench for the servo angle frame parser.
// It predicts every query reply from its own copy of the frame and angle
// state. Depends on safp_pkg and servo_angle_frame_parser.
module servo_angle_frame_parser_test
  import safp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomItems = 750;
  localparam int unsigned MaxReports = 60;

  // One query reply as seen on the result stream.
  typedef struct packed {
    logic        fresh;
    logic        angle_valid;
    logic [15:0] angle;
  } angle_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = CMD_BYTE;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_LOW_LIMIT;
  logic [15:0] cfg_data_i = '0;

  // Predicted state of the block.
  logic [7:0]  frame_buf [FRAME_LEN];
  int unsigned frame_fill;
  logic [15:0] angle_mem [SERVO_COUNT];
  logic        fresh_mem [SERVO_COUNT];
  logic [15:0] low_limit;
  logic [15:0] high_limit;

  angle_reply_t pending_replies [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  random_items = 0;
  bit           steady = 1'b0;

  servo_angle_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Numeric value of a stored character, wrapped like unsigned arithmetic.
  function automatic logic [31:0] digit_value(int unsigned pos);
    return {24'h0, frame_buf[pos]} - {24'h0, CH_ZERO};
  endfunction

  // Frame assembly and decode for one received character.
  function automatic void track_byte(logic [7:0] b);
    logic [31:0] id;
    logic [31:0] ang;
    if (b == CH_START) begin
      frame_buf[0] = b;
      frame_fill = 1;
      return;
    end
    if (frame_fill > 0 && frame_fill < FRAME_LEN) begin
      frame_buf[frame_fill] = b;
      frame_fill++;
    end
    if (b == CH_END && frame_fill == FRAME_LEN) begin
      if (frame_buf[4] == CH_P) begin
        id = (digit_value(1) * 100 + digit_value(2) * 10 + digit_value(3)) & 32'hFF;
        if (id < SERVO_COUNT) begin
          ang = digit_value(5) * 1000 + digit_value(6) * 100 + digit_value(7) * 10
                + digit_value(8);
          angle_mem[id] = ang[15:0];
          fresh_mem[id] = 1'b1;
        end
      end
      frame_fill = 0;
    end
  endfunction

  // Reply to a query; the fresh mark is consumed.
  function automatic void predict_query(logic [7:0] qid);
    angle_reply_t r;
    r = '0;
    if (qid < SERVO_COUNT && fresh_mem[qid]) begin
      r.fresh = 1'b1;
      if (angle_mem[qid] > low_limit && angle_mem[qid] < high_limit) begin
        r.angle_valid = 1'b1;
        r.angle = angle_mem[qid];
      end
      fresh_mem[qid] = 1'b0;
    end
    pending_replies.push_back(r);
  endfunction

  // Send one input transaction, sometimes with a random gap in front of it.
  task automatic send_item(cmd_e kind, logic [7:0] rx, logic [7:0] qid);
    if (!steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {qid, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == CMD_BYTE) track_byte(rx);
    else predict_query(qid);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b, 8'($urandom));
  endtask

  task automatic send_query(logic [7:0] qid);
    send_item(CMD_QUERY, 8'($urandom), qid);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop sending and wait until every predicted reply has been checked.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Limit register write, only ever issued while the block is idle.
  task automatic write_limit(reg_idx_e idx, logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_LOW_LIMIT) low_limit = value;
    else high_limit = value;
  endtask

  task automatic set_limits(logic [15:0] low, logic [15:0] high);
    write_limit(REG_LOW_LIMIT, low);
    write_limit(REG_HIGH_LIMIT, high);
  endtask

  // Replies to bad queries, stray bytes, restarts and every kind of frame.
  task automatic test_directed();
    send_query(8'hFF);
    send_query(8'h00);
    send_string("A!");
    send_string("#015P2499!");
    send_query(8'd15);
    send_query(8'd15);
    send_string("#0#007P0500!");
    send_query(8'd7);
    send_string("#0:3P1~0!");
    send_query(8'd3);
    send_string("#016P1000!#003Q1000!");
    send_query(8'd3);
    send_string("#004P2000ZY!");
    send_query(8'd4);
    send_string("#255P9999!");
    send_query(8'd15);
    send_query(8'd255);
  endtask

  // Limits at their extremes: fully open, fully closed and equal.
  task automatic test_limits();
    set_limits(16'h0000, 16'hFFFF);
    send_string("#001P0000!#002P0001!");
    send_query(8'd1);
    send_query(8'd2);
    set_limits(16'hFFFF, 16'h0000);
    send_string("#002P1234!");
    send_query(8'd2);
    set_limits(16'd1000, 16'd1000);
    send_string("#005P1000!#006P1001!");
    send_query(8'd5);
    send_query(8'd6);
  endtask

  // Draw an angle, often right at or next to one of the current limits.
  function automatic int unsigned pick_angle();
    int unsigned a;
    case ($urandom_range(3))
      0: a = low_limit + $urandom_range(2) - 1;
      1: a = high_limit + $urandom_range(2) - 1;
      default: a = $urandom_range(9999);
    endcase
    return (a > 9999) ? $urandom_range(9999) : a;
  endfunction

  // One reply frame with random content; returns the items it took.
  task automatic send_random_frame(output int unsigned count);
    logic [7:0]  chars [$];
    int unsigned id;
    int unsigned ang;
    int unsigned cut;
    chars = {};
    count = 0;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    case ($urandom_range(19))
      0, 1, 2: id = $urandom_range(16, 999);
      3: id = $urandom_range(999);
      default: id = $urandom_range(SERVO_COUNT - 1);
    endcase
    ang = pick_angle();
    chars.push_back(CH_START);
    chars.push_back(8'(CH_ZERO + id / 100));
    chars.push_back(8'(CH_ZERO + (id / 10) % 10));
    chars.push_back(8'(CH_ZERO + id % 10));
    chars.push_back(($urandom_range(99) < 90) ? CH_P : 8'($urandom));
    chars.push_back(8'(CH_ZERO + ang / 1000));
    chars.push_back(8'(CH_ZERO + (ang / 100) % 10));
    chars.push_back(8'(CH_ZERO + (ang / 10) % 10));
    chars.push_back(8'(CH_ZERO + ang % 10));
    // Occasionally a raw character in place of a digit.
    if ($urandom_range(99) < 12) chars[$urandom_range(1, 8)] = 8'($urandom);
    if ($urandom_range(99) < 8) begin
      // Overfull frame: extra characters after the tenth are dropped.
      repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom));
    end
    chars.push_back(CH_END);
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, chars.size() - 1) : chars.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < 3) begin
        send_query(8'($urandom_range(SERVO_COUNT - 1)));
        count++;
      end
      send_byte(chars[i]);
      count++;
    end
  endtask

  // Phases of random frames and queries, each under its own limit setting.
  task automatic test_random();
    int unsigned phase;
    int unsigned n;
    phase = 0;
    while (random_items < RandomItems) begin
      case (phase % 6)
        0: set_limits(LOW_LIMIT_RESET, HIGH_LIMIT_RESET);
        1: set_limits(16'h0000, 16'hFFFF);
        2: set_limits(16'($urandom_range(3000)), 16'($urandom_range(1000, 10000)));
        3: set_limits(16'($urandom), 16'($urandom));
        4: set_limits(16'hFFFF, 16'h0000);
        default: set_limits(16'd2000, 16'd2002);
      endcase
      steady = (phase == 3);
      repeat (12) begin
        send_random_frame(n);
        random_items += n;
        repeat ($urandom_range(2)) begin
          send_query(($urandom_range(99) < 85) ? 8'($urandom_range(SERVO_COUNT - 1))
                                                : 8'($urandom));
          random_items++;
        end
      end
      steady = 1'b0;
      phase++;
    end
  endtask

  // Result stream back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // Compare each reply with the oldest prediction.
  always @(posedge clk_i) begin
    angle_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected reply, expected none, actual fresh %0d valid %0d angle %0d",
                   $time, m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser[0] !== want.fresh) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: fresh mismatch, expected %0d, actual %0d",
                     $time, want.fresh, m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== want.angle_valid) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: angle_valid mismatch, expected %0d, actual %0d",
                     $time, want.angle_valid, m_axis_tuser[1]);
        end
        if (m_axis_tdata !== want.angle) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: angle mismatch, expected %0d, actual %0d",
                     $time, want.angle, m_axis_tdata);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("servo_angle_frame_parser_test NOT OK");
      $finish;
    end
  end

  initial begin
    frame_fill = 0;
    low_limit = LOW_LIMIT_RESET;
    high_limit = HIGH_LIMIT_RESET;
    for (int i = 0; i < SERVO_COUNT; i++) begin
      angle_mem[i] = '0;
      fresh_mem[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_limits();
    test_random();

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("servo_angle_frame_parser_test OK");
    end else begin
      $display("servo_angle_frame_parser_test NOT OK");
    end
    $finish;
  end

endmodule
